### rtl/agu_oldest_first_buffer_unit_macros.svh
// Assertion macros for the oldest-first address buffer.
// Used by the checker file; no other dependencies.
`ifndef AGU_OLDEST_FIRST_BUFFER_UNIT_MACROS_SVH
`define AGU_OLDEST_FIRST_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define AGU_OFB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define AGU_OFB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define AGU_OFB_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/agu_ofb_pkg.sv
// Shared types, constants and the circular tag-age function of the
// oldest-first address buffer. No dependencies.
package agu_ofb_pkg;

   localparam int ADDR_BITS      = 32;
   localparam int PORT_TAG_BITS  = 6;
   localparam int PORT_QIDX_BITS = 4;
   localparam int TAG_MAX_BITS   = 8;

   typedef struct packed {
      logic                          dispatch_valid;
      logic signed [ADDR_BITS-1:0]   base_operand;
      logic signed [ADDR_BITS-1:0]   offset_operand;
      logic [PORT_TAG_BITS-1:0]      request_tag;
      logic [PORT_QIDX_BITS-1:0]     queue_slot;
      logic                          squash_valid;
      logic [PORT_TAG_BITS-1:0]      squash_from_tag;
   } req_word_type;

   typedef struct packed {
      logic                          issue_valid;
      logic [ADDR_BITS-1:0]          issue_address;
      logic [PORT_TAG_BITS-1:0]      issue_tag;
      logic [PORT_QIDX_BITS-1:0]     issue_queue_slot;
   } rsp_word_type;

   // a is older than b when (b - a) mod 2^bits is nonzero and below half range
   function automatic logic tag_older(logic [TAG_MAX_BITS-1:0] a,
                                      logic [TAG_MAX_BITS-1:0] b,
                                      int unsigned bits);
      logic [TAG_MAX_BITS:0]   mask_wide;
      logic [TAG_MAX_BITS-1:0] diff;
      mask_wide = (9'd1 << bits) - 9'd1;
      diff      = (b - a) & mask_wide[TAG_MAX_BITS-1:0];
      return (diff != '0) && !diff[3'(bits - 1)];
   endfunction

endpackage

### rtl/agu_ofb_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on agu_ofb_pkg.
interface agu_ofb_req_if;
   import agu_ofb_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface agu_ofb_rsp_if;
   import agu_ofb_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/agu_ofb_select.sv
// Slot picker: oldest used slot and lowest free slot, both one-hot.
// Depends on agu_ofb_pkg for the tag-age function.
module agu_ofb_select #(
   parameter int SLOTS    = 4,
   parameter int TAG_BITS = 6
) (
   input  logic [SLOTS-1:0]               used,
   input  logic [SLOTS-1:0][TAG_BITS-1:0] tags,
   output logic [SLOTS-1:0]               oldest_oh,
   output logic [SLOTS-1:0]               free_oh
);
   import agu_ofb_pkg::*;

   // scan in slot order; replace only on strictly older so ties keep the lower slot
   always_comb begin
      logic                found;
      logic [TAG_BITS-1:0] cur_tag;
      found     = 1'b0;
      cur_tag   = '0;
      oldest_oh = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (used[i] && (!found || tag_older(TAG_MAX_BITS'(tags[i]),
                                             TAG_MAX_BITS'(cur_tag), TAG_BITS))) begin
            oldest_oh    = '0;
            oldest_oh[i] = 1'b1;
            cur_tag      = tags[i];
            found        = 1'b1;
         end
      end
   end

   always_comb begin
      logic seen_free;
      seen_free = 1'b0;
      free_oh   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         free_oh[i] = !used[i] && !seen_free;
         seen_free  = seen_free || !used[i];
      end
   end

endmodule

### rtl/agu_oldest_first_buffer_unit.sv
// Top level of the oldest-first address generation buffer.
// Depends on agu_ofb_pkg, agu_ofb_if and agu_ofb_select.
//
//   channel   dir  handshake     word
//   req_chan  in   valid/ready   dispatch, operands, tag, queue slot, squash
//   rsp_chan  out  valid/ready   issue valid, address, tag, queue slot
//
// Every request word yields exactly one response word.
// An accepted word goes from the input register to the response register: it sits
// in the input register while it passes through add, oldest pick and squash.
// Throughput is one word per cycle; the response register lets a new word
// enter while a finished one waits, and a stalled response stalls the input.
// Synchronous reset empties the buffer and both pipeline registers.
module agu_oldest_first_buffer_unit #(
   parameter int BUFFER_SLOTS     = 4,
   parameter int TAG_BITS         = 6,
   parameter int QUEUE_INDEX_BITS = 4
) (
   input  logic          clock,
   input  logic          reset,
   agu_ofb_req_if.sink   req_chan,
   agu_ofb_rsp_if.source rsp_chan
);
   import agu_ofb_pkg::*;

   // input register
   req_word_type in_word_ff;
   logic         in_valid_ff;
   logic         in_valid_in;

   // response register
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;

   // buffer slots; payload is only read where the used bit is set
   logic [BUFFER_SLOTS-1:0]                       slot_used_ff;
   logic [BUFFER_SLOTS-1:0]                       slot_used_in;
   logic [BUFFER_SLOTS-1:0][TAG_BITS-1:0]         slot_tag_ff;
   logic [BUFFER_SLOTS-1:0][ADDR_BITS-1:0]        slot_address_ff;
   logic [BUFFER_SLOTS-1:0][QUEUE_INDEX_BITS-1:0] slot_qidx_ff;

   logic                        advance;
   logic [BUFFER_SLOTS-1:0]     oldest_oh;
   logic [BUFFER_SLOTS-1:0]     free_oh;
   logic                        write_en;
   logic [ADDR_BITS-1:0]        new_address;
   logic [TAG_BITS-1:0]         new_tag;
   logic [TAG_BITS-1:0]         squash_tag;
   logic [QUEUE_INDEX_BITS-1:0] new_qidx;
   logic [ADDR_BITS-1:0]        iss_address;
   logic [TAG_BITS-1:0]         iss_tag;
   logic [QUEUE_INDEX_BITS-1:0] iss_qidx;

   // zero-extend or truncate between port field widths and storage widths
   logic [TAG_BITS+PORT_TAG_BITS-1:0]         req_tag_ext;
   logic [TAG_BITS+PORT_TAG_BITS-1:0]         sq_tag_ext;
   logic [QUEUE_INDEX_BITS+PORT_QIDX_BITS-1:0] req_qidx_ext;
   logic [TAG_BITS+PORT_TAG_BITS-1:0]         iss_tag_ext;
   logic [QUEUE_INDEX_BITS+PORT_QIDX_BITS-1:0] iss_qidx_ext;

   // process the held word when the response register is free or draining
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   assign req_tag_ext  = {{TAG_BITS{1'b0}}, in_word_ff.request_tag};
   assign sq_tag_ext   = {{TAG_BITS{1'b0}}, in_word_ff.squash_from_tag};
   assign req_qidx_ext = {{QUEUE_INDEX_BITS{1'b0}}, in_word_ff.queue_slot};
   assign new_tag      = req_tag_ext[TAG_BITS-1:0];
   assign squash_tag   = sq_tag_ext[TAG_BITS-1:0];
   assign new_qidx     = req_qidx_ext[QUEUE_INDEX_BITS-1:0];

   // address add wraps modulo 2^32
   assign new_address = in_word_ff.base_operand + in_word_ff.offset_operand;

   // fullness is judged on the contents before this word; issue does not free room
   assign write_en = in_word_ff.dispatch_valid && (|free_oh);

   agu_ofb_select #(
      .SLOTS    (BUFFER_SLOTS),
      .TAG_BITS (TAG_BITS)
   ) u_select (
      .used      (slot_used_ff),
      .tags      (slot_tag_ff),
      .oldest_oh (oldest_oh),
      .free_oh   (free_oh)
   );

   // one-hot read of the oldest slot; reads as zero when the buffer is empty
   always_comb begin
      iss_address = '0;
      iss_tag     = '0;
      iss_qidx    = '0;
      for (int i = 0; i < BUFFER_SLOTS; i++) begin
         iss_address = iss_address | ({ADDR_BITS{oldest_oh[i]}} & slot_address_ff[i]);
         iss_tag     = iss_tag | ({TAG_BITS{oldest_oh[i]}} & slot_tag_ff[i]);
         iss_qidx    = iss_qidx | ({QUEUE_INDEX_BITS{oldest_oh[i]}} & slot_qidx_ff[i]);
      end
   end

   assign iss_tag_ext  = {{PORT_TAG_BITS{1'b0}}, iss_tag};
   assign iss_qidx_ext = {{PORT_QIDX_BITS{1'b0}}, iss_qidx};

   always_comb begin
      rsp_word_in.issue_valid      = |oldest_oh;
      rsp_word_in.issue_address    = iss_address;
      rsp_word_in.issue_tag        = iss_tag_ext[PORT_TAG_BITS-1:0];
      rsp_word_in.issue_queue_slot = iss_qidx_ext[PORT_QIDX_BITS-1:0];
   end

   // order: write new entry, drop the issued one, then squash (new entry included)
   always_comb begin
      logic [TAG_BITS-1:0] tag_eff;
      logic                used;
      tag_eff = '0;
      used    = 1'b0;
      for (int i = 0; i < BUFFER_SLOTS; i++) begin
         tag_eff = (write_en && free_oh[i]) ? new_tag : slot_tag_ff[i];
         used    = (slot_used_ff[i] || (write_en && free_oh[i])) && !oldest_oh[i];
         if (in_word_ff.squash_valid && used &&
             !tag_older(TAG_MAX_BITS'(tag_eff), TAG_MAX_BITS'(squash_tag), TAG_BITS)) begin
            used = 1'b0;
         end
         slot_used_in[i] = used;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_used_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            slot_used_ff <= slot_used_in;
         end
      end
   end

   // payload registers: hold unless loaded
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_word_ff <= req_chan.data;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
      for (int i = 0; i < BUFFER_SLOTS; i++) begin
         if (advance && write_en && free_oh[i]) begin
            slot_address_ff[i] <= new_address;
            slot_tag_ff[i]     <= new_tag;
            slot_qidx_ff[i]    <= new_qidx;
         end
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

endmodule

### rtl/agu_ofb_checker.sv
// Port-level checker for the oldest-first address buffer, with its bind.
// Depends on agu_ofb_pkg and agu_oldest_first_buffer_unit_macros.svh.
`include "agu_oldest_first_buffer_unit_macros.svh"

module agu_ofb_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input agu_ofb_pkg::rsp_word_type rsp_data
);
   import agu_ofb_pkg::*;

   // a pending response word holds until taken
   `AGU_OFB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // an empty issue carries zero payload
   `AGU_OFB_ASSERT_IMP(a_empty_zero, clock, reset, rsp_valid && !rsp_data.issue_valid, rsp_data.issue_address == '0 && rsp_data.issue_tag == '0 && rsp_data.issue_queue_slot == '0, "empty issue with nonzero payload")

   // with no response pending the input side must be open
   `AGU_OFB_ASSERT_IMP(a_ready_open, clock, reset, !rsp_valid, req_ready, "input stalled with no response pending")

   // reset clears the response register
   `AGU_OFB_ASSERT_NXT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid, "response valid right after reset")

endmodule

bind agu_oldest_first_buffer_unit agu_ofb_checker u_agu_ofb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
